### rtl/wrd_pkg.sv
// shared types, constants and lookup functions for the week row day numbers block
// no dependencies
`default_nettype none

package wrd_pkg;

	localparam int YEAR_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 5;
	localparam int WOFF_W = 3;
	localparam int COL_W = 3;
	localparam int WDAY_W = 3;
	localparam int CUR_W = 8;
	localparam int CENT_W = 7;
	localparam int ZTERM_W = 6;
	localparam int ZSUM_W = 9;

	localparam int YEAR_MIN = 1583;
	localparam int YEAR_MAX = 9999;
	localparam int FEB_LEAP = 29;
	localparam int RECIP_100 = 5243;
	localparam int RECIP_100_SHIFT = 19;
	localparam int RECIP_7 = 293;
	localparam int RECIP_7_SHIFT = 11;
	localparam int ZSUM_BIAS = 280;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
	localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
	localparam logic [MONTH_W-1:0] MON_XJAN = 4'd13;
	localparam logic [MONTH_W-1:0] MON_XFEB = 4'd14;

	localparam logic [COL_W-1:0] COL_LAST = 3'd6;
	localparam logic signed [WOFF_W-1:0] WOFF_NEG_SAT = -3'sd3;
	localparam logic signed [WOFF_W-1:0] WOFF_NEG_MAX = -3'sd4;

	typedef struct packed {
		logic [DAY_W-1:0] day;
		logic [MONTH_W-1:0] month;
		logic signed [WOFF_W-1:0] woff;
		logic [WDAY_W-1:0] wday;
		logic leap;
	} wrd_date_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			MON_FEB: len = leap ? DAY_W'(FEB_LEAP) : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// floor(13 * (m + 1) / 5) for the shifted month 3..14
	function automatic logic [ZTERM_W-1:0] zeller_term(input logic [MONTH_W-1:0] m);
		logic [ZTERM_W-1:0] t;
		unique case (m)
			MON_MAR: t = 6'd10;
			MON_APR: t = 6'd13;
			MON_MAY: t = 6'd15;
			MON_JUN: t = 6'd18;
			MON_JUL: t = 6'd20;
			MON_AUG: t = 6'd23;
			MON_SEP: t = 6'd26;
			MON_OCT: t = 6'd28;
			MON_NOV: t = 6'd31;
			MON_DEC: t = 6'd33;
			MON_XJAN: t = 6'd36;
			MON_XFEB: t = 6'd39;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

### rtl/wrd_in_if.sv
// date request channel: valid, ready and the reference date with week offset
// depends on wrd_pkg
`default_nettype none

interface wrd_in_if;
	logic valid;
	logic ready;
	logic [wrd_pkg::YEAR_W-1:0] year;
	logic [wrd_pkg::MONTH_W-1:0] month;
	logic [wrd_pkg::DAY_W-1:0] day;
	logic signed [wrd_pkg::WOFF_W-1:0] week_shift;

	modport source(output valid, year, month, day, week_shift, input ready);
	modport sink(input valid, year, month, day, week_shift, output ready);
endinterface

`default_nettype wire

### rtl/wrd_out_if.sv
// day number result channel: valid, ready and one weekday column per transfer
// depends on wrd_pkg
`default_nettype none

interface wrd_out_if;
	logic valid;
	logic ready;
	logic [wrd_pkg::DAY_W-1:0] day_number;
	logic [wrd_pkg::COL_W-1:0] column;
	logic last;

	modport source(output valid, day_number, column, last, input ready);
	modport sink(input valid, day_number, column, last, output ready);
endinterface

`default_nettype wire

### rtl/wrd_weekday.sv
// five stage pipeline: input clamping, century split, leap year and weekday by zeller
// depends on wrd_pkg and wrd_in_if
`default_nettype none

module wrd_weekday (
	input  wire logic clk,
	input  wire logic arst_n,
	wrd_in_if.sink dates,
	output logic wk_valid,
	input  wire logic wk_ready,
	output wrd_pkg::wrd_date_t wk
);
	import wrd_pkg::*;

	localparam int PROD_W = 27;
	localparam int MOD_PROD_W = 20;

	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [YEAR_W-1:0] year_c, year_a;
	logic [MONTH_W-1:0] month_c, month_a;
	logic signed [WOFF_W-1:0] woff_c;

	logic [YEAR_W-1:0] year_s1, ya_s1;
	logic [MONTH_W-1:0] month_s1, ma_s1;
	logic [DAY_W-1:0] day_s1;
	logic signed [WOFF_W-1:0] woff_s1;

	logic [PROD_W-1:0] jy_prod, j_prod;
	logic [YEAR_W-1:0] year_s2, ya_s2;
	logic [CENT_W-1:0] jy_s2, j_s2;
	logic [MONTH_W-1:0] month_s2, ma_s2;
	logic [DAY_W-1:0] day_s2;
	logic signed [WOFF_W-1:0] woff_s2;

	logic [YEAR_W-1:0] ky_diff, k_diff;
	logic [CENT_W-1:0] ky;
	logic leap_c;
	logic [CENT_W-1:0] k_s3, j_s3;
	logic [ZTERM_W-1:0] t_s3;
	logic leap_s3;
	logic [MONTH_W-1:0] month_s3;
	logic [DAY_W-1:0] day_s3;
	logic signed [WOFF_W-1:0] woff_s3;

	logic [ZSUM_W:0] zsum;
	logic [ZSUM_W-1:0] sum_s4;
	logic leap_s4;
	logic [MONTH_W-1:0] month_s4;
	logic [DAY_W-1:0] day_s4;
	logic signed [WOFF_W-1:0] woff_s4;

	logic [MOD_PROD_W-1:0] q_prod;
	logic [CENT_W-1:0] q7;
	logic [ZSUM_W-1:0] h_full;
	logic [WDAY_W-1:0] h7, wday_c;
	wrd_date_t date_s5;

	assign adv_s5 = !valid_s5 || wk_ready;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign dates.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= dates.valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: clamp fields, shift jan and feb to the previous year
	always_comb begin
		priority if (dates.year < YEAR_W'(YEAR_MIN)) year_c = YEAR_W'(YEAR_MIN);
		else if (dates.year > YEAR_W'(YEAR_MAX)) year_c = YEAR_W'(YEAR_MAX);
		else year_c = dates.year;
		priority if (dates.month < MON_JAN) month_c = MON_JAN;
		else if (dates.month > MON_DEC) month_c = MON_DEC;
		else month_c = dates.month;
		woff_c = (dates.week_shift == WOFF_NEG_MAX) ? WOFF_NEG_SAT : dates.week_shift;
		if (month_c < MON_MAR) begin
			month_a = month_c + MON_DEC;
			year_a = year_c - YEAR_W'(1);
		end else begin
			month_a = month_c;
			year_a = year_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			year_s1 <= year_c;
			ya_s1 <= year_a;
			month_s1 <= month_c;
			ma_s1 <= month_a;
			day_s1 <= dates.day;
			woff_s1 <= woff_c;
		end
	end

	// stage 2: century by reciprocal multiply
	assign jy_prod = PROD_W'(year_s1) * PROD_W'(RECIP_100);
	assign j_prod = PROD_W'(ya_s1) * PROD_W'(RECIP_100);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			jy_s2 <= jy_prod[RECIP_100_SHIFT +: CENT_W];
			j_s2 <= j_prod[RECIP_100_SHIFT +: CENT_W];
			year_s2 <= year_s1;
			ya_s2 <= ya_s1;
			month_s2 <= month_s1;
			ma_s2 <= ma_s1;
			day_s2 <= day_s1;
			woff_s2 <= woff_s1;
		end
	end

	// stage 3: year within century, leap year, month term
	assign ky_diff = year_s2 - YEAR_W'(jy_s2) * YEAR_W'(100);
	assign k_diff = ya_s2 - YEAR_W'(j_s2) * YEAR_W'(100);
	assign ky = ky_diff[CENT_W-1:0];
	assign leap_c = ((year_s2[1:0] == 2'd0) && (ky != '0))
		|| ((ky == '0) && (jy_s2[1:0] == 2'd0));

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			k_s3 <= k_diff[CENT_W-1:0];
			j_s3 <= j_s2;
			t_s3 <= zeller_term(ma_s2);
			leap_s3 <= leap_c;
			month_s3 <= month_s2;
			day_s3 <= day_s2;
			woff_s3 <= woff_s2;
		end
	end

	// stage 4: congruence sum, biased to stay positive
	assign zsum = (ZSUM_W+1)'(ZSUM_BIAS) + (ZSUM_W+1)'(day_s3) + (ZSUM_W+1)'(t_s3)
		+ (ZSUM_W+1)'(k_s3) + (ZSUM_W+1)'(k_s3[CENT_W-1:2])
		+ (ZSUM_W+1)'(j_s3[CENT_W-1:2]) - (ZSUM_W+1)'({j_s3, 1'b0});

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			sum_s4 <= zsum[ZSUM_W-1:0];
			leap_s4 <= leap_s3;
			month_s4 <= month_s3;
			day_s4 <= day_s3;
			woff_s4 <= woff_s3;
		end
	end

	// stage 5: modulo 7 and shift to monday as zero
	assign q_prod = MOD_PROD_W'(sum_s4) * MOD_PROD_W'(RECIP_7);
	assign q7 = q_prod[RECIP_7_SHIFT +: CENT_W];
	assign h_full = sum_s4 - ZSUM_W'(q7) * ZSUM_W'(7);
	assign h7 = h_full[WDAY_W-1:0];
	assign wday_c = (h7 >= WDAY_W'(2)) ? h7 - WDAY_W'(2) : h7 + WDAY_W'(5);

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			date_s5.day <= day_s4;
			date_s5.month <= month_s4;
			date_s5.woff <= woff_s4;
			date_s5.wday <= wday_c;
			date_s5.leap <= leap_s4;
		end
	end

	assign wk_valid = valid_s5;
	assign wk = date_s5;

`ifndef SYNTHESIS
	a_wday_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> date_s5.wday <= COL_LAST)
		else $error("weekday out of range");
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (date_s5.month >= MON_JAN) && (date_s5.month <= MON_DEC))
		else $error("clamped month out of range");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !wk_ready |=> valid_s5 && $stable(date_s5))
		else $error("stalled weekday result changed");
`endif

endmodule

`default_nettype wire

### rtl/wrd_emit.sv
// week start, month boundary correction and serial output of the seven columns
// depends on wrd_pkg and wrd_out_if
`default_nettype none

module wrd_emit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wk_valid,
	output logic wk_ready,
	input  wire wrd_pkg::wrd_date_t wk,
	wrd_out_if.source days
);
	import wrd_pkg::*;

	logic active_q;
	logic signed [CUR_W-1:0] cur_q;
	logic [MONTH_W-1:0] cm_q;
	logic [COL_W-1:0] col_q;
	logic leap_q;

	logic out_valid_q;
	logic [DAY_W-1:0] out_day_q;
	logic [COL_W-1:0] out_col_q;
	logic out_last_q;

	logic load_out, take;
	logic signed [CUR_W-1:0] woff_x, cur_init, cur_fix;
	logic [MONTH_W-1:0] prev_m, next_m, cm_fix;
	logic [DAY_W-1:0] len_cur, len_prev;

	assign load_out = active_q && (!out_valid_q || days.ready);
	assign take = !active_q || (load_out && (col_q == COL_LAST));
	assign wk_ready = take;

	assign woff_x = CUR_W'(wk.woff);
	assign cur_init = $signed(CUR_W'(wk.day)) - $signed(CUR_W'(wk.wday))
		+ (woff_x <<< 3) - woff_x;

	always_comb begin
		prev_m = (cm_q == MON_JAN) ? MON_DEC : cm_q - MONTH_W'(1);
		next_m = (cm_q == MON_DEC) ? MON_JAN : cm_q + MONTH_W'(1);
		len_cur = month_len(cm_q, leap_q);
		len_prev = month_len(prev_m, leap_q);
		priority if (cur_q < $signed(CUR_W'(1))) begin
			cur_fix = cur_q + $signed(CUR_W'(len_prev));
			cm_fix = prev_m;
		end else if (cur_q > $signed(CUR_W'(len_cur))) begin
			cur_fix = cur_q - $signed(CUR_W'(len_cur));
			cm_fix = next_m;
		end else begin
			cur_fix = cur_q;
			cm_fix = cm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q <= '0;
		end else if (take && wk_valid) begin
			active_q <= 1'b1;
			col_q <= '0;
		end else if (load_out) begin
			if (col_q == COL_LAST) begin
				active_q <= 1'b0;
				col_q <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && wk_valid) begin
			cur_q <= cur_init;
			cm_q <= wk.month;
			leap_q <= wk.leap;
		end else if (load_out) begin
			cur_q <= cur_fix + CUR_W'(1);
			cm_q <= cm_fix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (days.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_day_q <= cur_fix[DAY_W-1:0];
			out_col_q <= col_q;
			out_last_q <= (col_q == COL_LAST);
		end
	end

	assign days.valid = out_valid_q;
	assign days.day_number = out_day_q;
	assign days.column = out_col_q;
	assign days.last = out_last_q;

`ifndef SYNTHESIS
	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_day_q != '0)
		else $error("day number zero on output");
	a_take_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		take && active_q |-> load_out && (col_q == COL_LAST))
		else $error("new week started before seven columns sent");
	a_idle_col: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> col_q == '0)
		else $error("column count not cleared while idle");
	a_month_valid: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cm_q >= MON_JAN) && (cm_q <= MON_DEC))
		else $error("running month out of range");
	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && active_q && (col_q != COL_LAST) |=> active_q && (col_q != '0))
		else $error("column sequence broken");
`endif

endmodule

`default_nettype wire

### rtl/week_row_day_numbers.sv
// Takes a Gregorian date with a week offset and returns the day-of-month numbers of the
// Monday-to-Sunday week that lies that many weeks away, one column per result transfer,
// the Sunday column marked last. The weekday is found by Zeller's congruence in a five
// stage pipeline; month crossings use the month lengths with leap February and wrap at
// the year ends. Each date yields seven column transfers on the single result channel,
// and a new date is taken while the previous week is still being sent. Years are clamped
// to 1583..9999, months to 1..12 and an offset of -4 to -3.
// depends on wrd_pkg, wrd_in_if, wrd_out_if, wrd_weekday and wrd_emit
`default_nettype none

module week_row_day_numbers (
	input  wire logic clk,
	input  wire logic arst_n,
	wrd_in_if.sink dates,
	wrd_out_if.source days
);
	import wrd_pkg::*;

	logic wk_valid;
	logic wk_ready;
	wrd_date_t wk;

	wrd_weekday u_weekday (
		.clk(clk),
		.arst_n(arst_n),
		.dates(dates),
		.wk_valid(wk_valid),
		.wk_ready(wk_ready),
		.wk(wk)
	);

	wrd_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.wk_valid(wk_valid),
		.wk_ready(wk_ready),
		.wk(wk),
		.days(days)
	);

endmodule

`default_nettype wire
